[hdl/uv_sphere_cell_vertices_macros.svh]
// Assertion macros used by the sphere vertex top level.
`ifndef UV_SPHERE_CELL_VERTICES_MACROS_SVH
`define UV_SPHERE_CELL_VERTICES_MACROS_SVH
`ifndef NO_ASSERTIONS
`define UVS_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);
`define UVS_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);
`else
`define UVS_ASSERT_IMP(lbl, ant, con, msg)
`define UVS_ASSERT_NXT(lbl, ant, con, msg)
`endif
`endif

[hdl/uvs_pkg.sv]
// Constants, types and corner tables of the sphere vertex block.
`default_nettype none
package uvs_pkg;
  localparam int MAX_DIVISIONS   = 256;
  localparam int COORD_FRAC_BITS = 14;
  localparam int DIV_W           = 9;
  localparam int IDX_W           = 8;
  localparam int REM_W           = 10;
  localparam int PHASE_W         = 16;
  localparam int MAG_W           = 31;
  localparam int DIV_STEPS       = 16;
  localparam int SINE_LAT        = 5;
  localparam int PIPE_LAST       = 1 + DIV_STEPS + SINE_LAT + 1;
  localparam int SH_XZ           = 60 - COORD_FRAC_BITS;
  localparam int SH_Y            = 30 - COORD_FRAC_BITS;
  localparam logic [2:0] LAST_SLOT = 3'd5;

  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  typedef struct packed {
    logic       err;
    logic [2:0] slot;
    logic       tex_u;
    logic       tex_v;
    logic       last;
  } sb_t;

  // slots 1, 2 and 4 sit on the upper latitude
  function automatic logic slot_lat1(input logic [2:0] s);
    return (s == 3'd1) || (s == 3'd2) || (s == 3'd4);
  endfunction

  // slots 2, 4 and 5 sit on the end longitude
  function automatic logic slot_lon1(input logic [2:0] s);
    return (s == 3'd2) || (s == 3'd4) || (s == 3'd5);
  endfunction
endpackage
`default_nettype wire

[hdl/uvs_ifs.sv]
// Stream interfaces of the sphere vertex block: cell beats in, vertex beats out.
`default_nettype none
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] lat_index;
  logic [7:0] lon_index;
  modport source (output valid, output lat_index, output lon_index, input ready);
  modport sink (input valid, input lat_index, input lon_index, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic               tex_u;
  logic               tex_v;
  logic [2:0]         corner_slot;
  logic               index_error;
  logic               last_vertex;
  modport source (output valid, output pos_x, output pos_y, output pos_z, output tex_u,
                  output tex_v, output corner_slot, output index_error,
                  output last_vertex, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, input tex_u,
                input tex_v, input corner_slot, input index_error, input last_vertex,
                output ready);
endinterface
`default_nettype wire

[hdl/uv_sphere_cell_vertices.sv]
// Top level: UV sphere cell to six triangle vertices, divider cell chains and sine pipelines.
//
//  channel | dir | beat                                         | handshake
//  in_ch   | in  | lat_index, lon_index                         | valid/ready
//  out_ch  | out | pos_x/y/z, tex_u/v, corner_slot, error, last | valid/ready
//  cfg     | in  | divisions                                    | cfg_we
//
// A valid cell yields six vertex beats, one per cycle while the output does not stall;
// a cell with an index out of range yields one error beat. The issue counter sets the number of beats.
// The path from issue to output runs through the entry stage, 16 divider cells, 5 sine stages,
// product, round.
// Reset clears the valid bits and the issue counter; divisions resets to 16.
// A stall on the output freezes the whole pipeline; a new cell is taken while idle or on the last issue cycle.
`default_nettype none
`include "uv_sphere_cell_vertices_macros.svh"
module uv_sphere_cell_vertices
  import uvs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [DIV_W-1:0] cfg_wdata,
  uvs_in_if.sink                in_ch,
  uvs_out_if.source             out_ch
);
  logic [DIV_W-1:0] div_r;
  logic [IDX_W-1:0] la_r, lo_r;
  logic [DIV_W-1:0] n_r;
  logic             err_r, busy_r;
  logic [2:0]       slot_r;
  logic             adv, accept, last_issue;
  logic [DIV_W-1:0] n_eff;
  logic             in_err;

  logic [PIPE_LAST:0] vld_r;
  sb_t                sb_r [0:PIPE_LAST];
  sb_t                sb_nxt;

  logic [REM_W-1:0]   lat_rem [0:DIV_STEPS];
  logic [REM_W-1:0]   lat_div [0:DIV_STEPS];
  logic [PHASE_W-1:0] lat_quo [0:DIV_STEPS];
  logic [REM_W-1:0]   lon_rem [0:DIV_STEPS];
  logic [REM_W-1:0]   lon_div [0:DIV_STEPS];
  logic [PHASE_W-1:0] lon_quo [0:DIV_STEPS];

  logic [DIV_W-1:0]   iv, jv;
  logic [REM_W-1:0]   dlat, dlon, rlat0, rlon0;
  logic [PHASE_W-1:0] latp, lonp;

  logic [MAG_W-1:0] slat, clat, slon, clon;
  logic             sl, cl, sn, cn;
  logic [60:0]      px_r, pz_r;
  logic [MAG_W-1:0] ym_r;
  logic             nx_r, ny_r, nz_r;
  logic [60:0]      sx, sz;
  logic [31:0]      sy;
  logic [15:0]      mx, my, mz;
  logic signed [15:0] pos_x_r, pos_y_r, pos_z_r;

  assign adv        = !vld_r[PIPE_LAST] || out_ch.ready;
  assign last_issue = err_r || (slot_r == LAST_SLOT);
  assign in_ch.ready = adv && (!busy_r || last_issue);
  assign accept     = in_ch.valid && in_ch.ready;

  always_comb begin
    n_eff  = (div_r > DIV_W'(MAX_DIVISIONS)) ? DIV_W'(MAX_DIVISIONS) : div_r;
    in_err = ({1'b0, in_ch.lat_index} >= n_eff) || ({1'b0, in_ch.lon_index} >= n_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r <= DIV_W'(16);
    end else if (cfg_we) begin
      div_r <= cfg_wdata;
    end
  end

  // issue sequencer: hold the cell, step through the corner slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= 3'd0;
    end else if (adv) begin
      if (accept) begin
        busy_r <= 1'b1;
        slot_r <= 3'd0;
      end else if (busy_r && last_issue) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        slot_r <= slot_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      la_r  <= in_ch.lat_index;
      lo_r  <= in_ch.lon_index;
      n_r   <= n_eff;
      err_r <= in_err;
    end
  end

  always_comb begin
    iv    = {1'b0, la_r} + DIV_W'(slot_lat1(slot_r));
    jv    = {1'b0, lo_r} + DIV_W'(slot_lon1(slot_r));
    dlat  = {n_r, 1'b0};
    dlon  = {1'b0, n_r};
    rlat0 = ({1'b0, iv} >= dlat) ? ({1'b0, iv} - dlat) : {1'b0, iv};
    rlon0 = ({1'b0, jv} >= dlon) ? ({1'b0, jv} - dlon) : {1'b0, jv};
    sb_nxt.err   = err_r;
    sb_nxt.slot  = err_r ? 3'd0 : slot_r;
    sb_nxt.tex_u = !err_r && slot_lon1(slot_r);
    sb_nxt.tex_v = !err_r && !slot_lat1(slot_r);
    sb_nxt.last  = last_issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAST-1:0], busy_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0]    <= sb_nxt;
      lat_rem[0] <= rlat0;
      lat_div[0] <= dlat;
      lat_quo[0] <= '0;
      lon_rem[0] <= rlon0;
      lon_div[0] <= dlon;
      lon_quo[0] <= '0;
      for (int k = 1; k <= PIPE_LAST; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    uvs_div_cell u_lat (
      .clk(clk), .en(adv),
      .rem_i(lat_rem[g]), .div_i(lat_div[g]), .quo_i(lat_quo[g]),
      .rem_o(lat_rem[g+1]), .div_o(lat_div[g+1]), .quo_o(lat_quo[g+1])
    );
    uvs_div_cell u_lon (
      .clk(clk), .en(adv),
      .rem_i(lon_rem[g]), .div_i(lon_div[g]), .quo_i(lon_quo[g]),
      .rem_o(lon_rem[g+1]), .div_o(lon_div[g+1]), .quo_o(lon_quo[g+1])
    );
  end

  // latitude starts a quarter turn back
  assign latp = lat_quo[DIV_STEPS] + 16'hC000;
  assign lonp = lon_quo[DIV_STEPS];

  uvs_sine u_slat (.clk(clk), .en(adv), .phase_i(latp), .mag_o(slat), .neg_o(sl));
  uvs_sine u_clat (.clk(clk), .en(adv), .phase_i(latp + 16'h4000), .mag_o(clat), .neg_o(cl));
  uvs_sine u_slon (.clk(clk), .en(adv), .phase_i(lonp), .mag_o(slon), .neg_o(sn));
  uvs_sine u_clon (.clk(clk), .en(adv), .phase_i(lonp + 16'h4000), .mag_o(clon), .neg_o(cn));

  always_comb begin
    sx = px_r + (61'd1 << (SH_XZ - 1));
    sz = pz_r + (61'd1 << (SH_XZ - 1));
    sy = {1'b0, ym_r} + (32'd1 << (SH_Y - 1));
    mx = 16'(sx[60:SH_XZ]);
    mz = 16'(sz[60:SH_XZ]);
    my = 16'(sy[31:SH_Y]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= 61'(62'(clat) * 62'(clon));
      pz_r <= 61'(62'(clat) * 62'(slon));
      ym_r <= slat;
      nx_r <= cl ^ cn;
      nz_r <= cl ^ sn;
      ny_r <= sl;
      // drop the position on an error beat
      pos_x_r <= sb_r[PIPE_LAST-1].err ? 16'sd0 : (nx_r ? -$signed(mx) : $signed(mx));
      pos_y_r <= sb_r[PIPE_LAST-1].err ? 16'sd0 : (ny_r ? -$signed(my) : $signed(my));
      pos_z_r <= sb_r[PIPE_LAST-1].err ? 16'sd0 : (nz_r ? -$signed(mz) : $signed(mz));
    end
  end

  assign out_ch.valid       = vld_r[PIPE_LAST];
  assign out_ch.pos_x       = pos_x_r;
  assign out_ch.pos_y       = pos_y_r;
  assign out_ch.pos_z       = pos_z_r;
  assign out_ch.tex_u       = sb_r[PIPE_LAST].tex_u;
  assign out_ch.tex_v       = sb_r[PIPE_LAST].tex_v;
  assign out_ch.corner_slot = sb_r[PIPE_LAST].slot;
  assign out_ch.index_error = sb_r[PIPE_LAST].err;
  assign out_ch.last_vertex = sb_r[PIPE_LAST].last;

  `UVS_ASSERT_NXT(a_accept_starts, accept, busy_r && (slot_r == 3'd0), "accept did not start issue")
  `UVS_ASSERT_IMP(a_slot_range, busy_r, slot_r <= LAST_SLOT, "issue slot out of range")
  `UVS_ASSERT_IMP(a_err_single, out_ch.valid && out_ch.index_error, out_ch.last_vertex && (out_ch.corner_slot == 3'd0) && (out_ch.pos_y == 16'sd0), "error beat malformed")
endmodule
`default_nettype wire

[hdl/uvs_div_cell.sv]
// One restoring division step: shift the remainder, subtract the divisor, emit a quotient bit.
`default_nettype none
module uvs_div_cell
  import uvs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [REM_W-1:0]   rem_i,
  input  wire logic [REM_W-1:0]   div_i,
  input  wire logic [PHASE_W-1:0] quo_i,
  output logic      [REM_W-1:0]   rem_o,
  output logic      [REM_W-1:0]   div_o,
  output logic      [PHASE_W-1:0] quo_o
);
  logic [REM_W:0]   sh;
  logic [REM_W:0]   diff;
  logic             bit_q;
  logic [REM_W-1:0] rem_nxt;

  always_comb begin
    sh      = {rem_i, 1'b0};
    diff    = sh - {1'b0, div_i};
    bit_q   = (sh >= {1'b0, div_i});
    rem_nxt = bit_q ? diff[REM_W-1:0] : sh[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      div_o <= div_i;
      quo_o <= {quo_i[PHASE_W-2:0], bit_q};
    end
  end
endmodule
`default_nettype wire

[hdl/uvs_sine.sv]
// Pipelined polynomial sine of a 16-bit turn phase: Q30 magnitude and sign, five stages.
`default_nettype none
module uvs_sine
  import uvs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [PHASE_W-1:0] phase_i,
  output logic      [MAG_W-1:0]   mag_o,
  output logic                    neg_o
);
  logic [14:0]      x;
  logic             neg0;
  logic [MAG_W-1:0] t1_r, t2_r, t3_r, t4_r;
  logic [MAG_W-1:0] sq2_r, sq3_r;
  logic [29:0]      r3_r;
  logic [30:0]      r4_r;
  logic [3:0]       neg_r;
  logic [61:0]      p_sq, p_t, p_r4;
  logic [57:0]      p_c;
  logic [60:0]      p_r;

  always_comb begin
    x = {1'b0, phase_i[13:0]};
    if (phase_i[14]) begin
      x = 15'd16384 - {1'b0, phase_i[13:0]};
    end
    neg0 = phase_i[15] && (x != 15'd0);
    p_sq = 62'(t1_r) * 62'(t1_r);
    p_c  = 58'(sq2_r) * 58'(SIN_C);
    p_r  = 61'(sq3_r) * 61'(r3_r);
    p_t  = 62'(t4_r) * 62'(r4_r);
    p_r4 = p_t;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: fold into the first quadrant
      t1_r     <= {x, 16'd0};
      neg_r[0] <= neg0;
      // stage 2: t squared
      sq2_r    <= p_sq[60:30];
      t2_r     <= t1_r;
      neg_r[1] <= neg_r[0];
      // stage 3: inner term
      r3_r     <= SIN_B - 30'(p_c[57:30]);
      sq3_r    <= sq2_r;
      t3_r     <= t2_r;
      neg_r[2] <= neg_r[1];
      // stage 4: outer term
      r4_r     <= SIN_A - p_r[60:30];
      t4_r     <= t3_r;
      neg_r[3] <= neg_r[2];
      // stage 5: final product
      mag_o    <= p_r4[60:30];
      neg_o    <= neg_r[3];
    end
  end
endmodule
`default_nettype wire
